/* design/stream_find_replace_macros.svh */
// ----------------------------------------------------------------------------
// Stream find and replace assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_MACROS_SVH
`define STREAM_FIND_REPLACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// Stream find and replace package
// Widths, register indexes, word types and byte selection shared by the block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int REG_BYTES       = 16;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int BYTE_W          = 8;
  localparam int REG_W           = 64;
  localparam int LEN_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int BURST_CNT_W     = $clog2(REG_BYTES + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_HI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_LEN = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              final_byte;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_stream;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic shift;
  } win_ctrl_t;

  typedef struct packed {
    logic load;
    logic advance;
  } burst_ctrl_t;

  // Byte k of a 16-byte value split over two 64-bit registers.
  function automatic logic [BYTE_W-1:0] pick_byte(input logic [REG_W-1:0] lo,
                                                  input logic [REG_W-1:0] hi,
                                                  input logic [3:0] k);
    logic [REG_W-1:0] src;
    src = k[3] ? hi : lo;
    return src[{k[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

/* design/sfr_stream_if.sv */
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel carrying one word of type T per handshake.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/sfr_win_cell.sv */
// ----------------------------------------------------------------------------
// Window cell
// Holds one byte of the match window and compares it with its pattern byte.
// ----------------------------------------------------------------------------
module sfr_win_cell (
  input  logic                      clk,
  input  sfr_pkg::win_ctrl_t        ctrl,
  input  logic                      sel,
  input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
  input  logic [sfr_pkg::BYTE_W-1:0] pattern,
  input  logic [sfr_pkg::BYTE_W-1:0] right_byte,
  output logic [sfr_pkg::BYTE_W-1:0] merged,
  output logic                      eq
);

  logic [sfr_pkg::BYTE_W-1:0] held;

  // The arriving byte lands in the cell at the current fill position.
  assign merged = sel ? in_byte : held;
  assign eq     = (merged == pattern);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      held <= ctrl.shift ? right_byte : merged;
    end
  end

endmodule

/* design/sfr_burst_cell.sv */
// ----------------------------------------------------------------------------
// Burst cell
// One slot of the result burst line, shifting toward the output register.
// ----------------------------------------------------------------------------
module sfr_burst_cell (
  input  logic                clk,
  input  sfr_pkg::burst_ctrl_t ctrl,
  input  sfr_pkg::out_word_t  fresh,
  input  sfr_pkg::out_word_t  right,
  output sfr_pkg::out_word_t  held
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      held <= fresh;
    end else if (ctrl.advance) begin
      held <= right;
    end
  end

endmodule

/* design/stream_find_replace.sv */
// ----------------------------------------------------------------------------
// Stream find and replace
// Greedy, non-overlapping, left-to-right replacement of a byte pattern.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, unless the output stalls, as long
// as each byte yields at most one result word. A byte whose results form a
// burst of n words (a replacement, or the flush at the end of a stream) holds
// the text input until its last word enters the output register, as the burst
// line drains one word per cycle into it unless the output stalls. The match
// window is a row of cells, one per pattern byte, that compare in parallel;
// MAX_PATTERN caps the window depth at up to 16 bytes. Configuration is for
// the user to write only while the block is idle; the block does not enforce
// it. A write to the match length empties the window.
module stream_find_replace #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::REG_W-1:0]     cfg_data,
  sfr_stream_if.sink                    text,
  sfr_stream_if.source                  edited
);

  localparam int WIN_DEPTH = (MAX_PATTERN < sfr_pkg::REG_BYTES) ? MAX_PATTERN
                                                                : sfr_pkg::REG_BYTES;
  localparam int CNT_W = $clog2(WIN_DEPTH + 1);
  localparam int NB    = sfr_pkg::REG_BYTES;
  localparam int BW    = sfr_pkg::BYTE_W;
  localparam int LW    = sfr_pkg::LEN_W;
  localparam int BCW   = sfr_pkg::BURST_CNT_W;

  logic [sfr_pkg::REG_W-1:0] match_lo;
  logic [sfr_pkg::REG_W-1:0] match_hi;
  logic [LW-1:0]             match_len;
  logic [sfr_pkg::REG_W-1:0] repl_lo;
  logic [sfr_pkg::REG_W-1:0] repl_hi;
  logic [LW-1:0]             repl_len;

  logic [CNT_W-1:0]          count;
  logic [BCW-1:0]            bcnt;
  logic                      out_valid;
  sfr_pkg::out_word_t        out_word;

  logic [LW-1:0]             eff_len;
  logic [LW-1:0]             repl_n;
  logic                      pass;
  logic                      full;
  logic                      hit;
  logic                      fin;
  logic [BW-1:0]             in_byte;
  logic                      accept;
  logic                      advance;
  logic                      marker;
  logic [BCW-1:0]            burst_n;

  logic [BW-1:0]             merged [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]      eq;
  logic [WIN_DEPTH-1:0]      ok;
  sfr_pkg::out_word_t        slot [NB];
  sfr_pkg::out_word_t        fresh [NB];

  sfr_pkg::win_ctrl_t        win_ctrl;
  sfr_pkg::burst_ctrl_t      burst_ctrl;

  assign in_byte = text.data.data_byte;
  assign fin     = text.data.final_byte;

  // Effective lengths, saturated to the window depth and the burst depth.
  assign eff_len = (match_len > LW'(WIN_DEPTH)) ? LW'(WIN_DEPTH) : match_len;
  assign repl_n  = (repl_len > LW'(NB)) ? LW'(NB) : repl_len;
  assign pass    = (eff_len == '0);
  assign full    = ((6'(count) + 6'd1) == 6'(eff_len));
  assign hit     = &ok;

  assign advance     = (bcnt != '0) && (!out_valid || edited.ready);
  assign text.ready  = (bcnt == '0) || ((bcnt == BCW'(1)) && advance);
  assign accept      = text.valid && text.ready;

  assign win_ctrl.load      = accept && !pass;
  assign win_ctrl.shift     = full && !hit;
  assign burst_ctrl.load    = accept;
  assign burst_ctrl.advance = advance;

  assign edited.valid = out_valid;
  assign edited.data  = out_word;

  // Match window cells.
  for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_win
    logic [BW-1:0] right_byte;
    if (j == WIN_DEPTH - 1) begin : g_last
      assign right_byte = in_byte;
    end else begin : g_mid
      assign right_byte = merged[j+1];
    end

    sfr_win_cell u_cell (
      .clk        (clk),
      .ctrl       (win_ctrl),
      .sel        (6'(count) == 6'(j)),
      .in_byte    (in_byte),
      .pattern    (sfr_pkg::pick_byte(match_lo, match_hi, 4'(j))),
      .right_byte (right_byte),
      .merged     (merged[j]),
      .eq         (eq[j])
    );

    // Cells past the pattern length do not take part in the compare.
    assign ok[j] = eq[j] || (6'(j) >= 6'(eff_len));
  end

  // Number of result words this byte produces.
  always_comb begin
    burst_n = '0;
    if (pass) begin
      burst_n = BCW'(1);
    end else if (full && hit) begin
      burst_n = BCW'(repl_n);
    end else if (full) begin
      burst_n = fin ? BCW'(eff_len) : BCW'(1);
    end else begin
      burst_n = fin ? BCW'(6'(count) + 6'd1) : '0;
    end
    marker = fin && (burst_n == '0);
    if (marker) begin
      burst_n = BCW'(1);
    end
  end

  // Burst line: slot 0 feeds the output register.
  for (genvar j = 0; j < NB; j++) begin : g_burst
    sfr_pkg::out_word_t right;
    logic [BW-1:0]      src_byte;

    if (j == NB - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = slot[j+1];
    end

    if (j < WIN_DEPTH) begin : g_win_src
      assign src_byte = pass ? in_byte
                      : ((full && hit) ? sfr_pkg::pick_byte(repl_lo, repl_hi, 4'(j))
                                       : merged[j]);
    end else begin : g_repl_src
      assign src_byte = sfr_pkg::pick_byte(repl_lo, repl_hi, 4'(j));
    end

    assign fresh[j].out_byte      = marker ? '0 : src_byte;
    assign fresh[j].byte_valid    = !marker;
    assign fresh[j].end_of_stream = fin && (6'(j) + 6'd1 == 6'(burst_n));

    sfr_burst_cell u_cell (
      .clk   (clk),
      .ctrl  (burst_ctrl),
      .fresh (fresh[j]),
      .right (right),
      .held  (slot[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match_lo  <= '0;
      match_hi  <= '0;
      match_len <= '0;
      repl_lo   <= '0;
      repl_hi   <= '0;
      repl_len  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        sfr_pkg::CFG_MATCH_LO:  match_lo  <= cfg_data;
        sfr_pkg::CFG_MATCH_HI:  match_hi  <= cfg_data;
        sfr_pkg::CFG_MATCH_LEN: match_len <= cfg_data[LW-1:0];
        sfr_pkg::CFG_REPL_LO:   repl_lo   <= cfg_data;
        sfr_pkg::CFG_REPL_HI:   repl_hi   <= cfg_data;
        sfr_pkg::CFG_REPL_LEN:  repl_len  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_write && (cfg_index == sfr_pkg::CFG_MATCH_LEN)) begin
      count <= '0;
    end else if (accept) begin
      if (pass || fin || (full && hit)) begin
        count <= '0;
      end else if (full) begin
        // A miss drops the oldest byte and keeps the rest.
        count <= CNT_W'(eff_len - LW'(1));
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcnt <= '0;
    end else if (accept) begin
      bcnt <= burst_n;
    end else if (advance) begin
      bcnt <= bcnt - BCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (edited.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= slot[0];
    end
  end

endmodule

/* design/sfr_checker.sv */
// ----------------------------------------------------------------------------
// Stream find and replace checker
// Port-level checks on the result channel, attached to the top level.
// ----------------------------------------------------------------------------
`include "stream_find_replace_macros.svh"

module sfr_port_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input sfr_pkg::out_word_t out_word
);

  // A stalled word stays on the channel unchanged.
  `SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word changed while stalled")

  // A word without a byte only ever closes a stream.
  `SFR_ASSERT_NOW(a_marker_eos, out_valid && !out_word.byte_valid, out_word.end_of_stream, "bare word without end of stream")

  // A word without a byte carries a zero byte.
  `SFR_ASSERT_NOW(a_marker_zero, out_valid && !out_word.byte_valid, out_word.out_byte == '0, "bare word with nonzero byte")

endmodule

bind stream_find_replace sfr_port_checker u_sfr_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (edited.valid),
  .out_ready (edited.ready),
  .out_word  (edited.data)
);

/* test/sfr_checker.sv */
// ----------------------------------------------------------------------------
// Stream find and replace checker
// Watches the register port and both channels of the block. It keeps its own
// copy of the registers and of the match window, predicts the result words of
// every text word taken in, and compares them in order with the words that
// leave on the edited channel.
// ----------------------------------------------------------------------------
module sfr_checker #(
  parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::REG_W-1:0]     cfg_data,
  input  logic                          text_valid,
  input  logic                          text_ready,
  input  sfr_pkg::in_word_t             text_data,
  input  logic                          edited_valid,
  input  logic                          edited_ready,
  input  sfr_pkg::out_word_t            edited_data,
  output int                            words_due,
  output int                            words_seen,
  output int                            mismatches
);

  logic [63:0]        match_lo, match_hi, repl_lo, repl_hi;
  logic [4:0]         match_len, repl_len;
  logic [7:0]         window [16];
  int                 fill;
  int                 seen;
  int                 errs;
  sfr_pkg::out_word_t due_q [$];

  function automatic logic [7:0] byte_at(input logic [63:0] lo, input logic [63:0] hi,
                                         input int k);
    logic [127:0] both;
    both = {hi, lo};
    return both[8*k +: 8];
  endfunction

  function automatic void push_word(input logic [7:0] b, input logic v);
    sfr_pkg::out_word_t w;
    w.out_byte      = b;
    w.byte_valid    = v;
    w.end_of_stream = 1'b0;
    due_q.push_back(w);
  endfunction

  // Greedy left-to-right replacement: the window fills up to the pattern
  // length, then either turns into the replacement or sheds its oldest byte.
  function automatic void edit_text(input logic [7:0] b, input logic fin);
    int                 plen;
    int                 rlen;
    int                 produced;
    int                 k;
    bit                 hit;
    sfr_pkg::out_word_t last;
    plen = int'(match_len);
    if (plen > 16) plen = 16;
    if (plen > MAX_PATTERN) plen = MAX_PATTERN;
    rlen = int'(repl_len);
    if (rlen > 16) rlen = 16;
    produced = 0;
    if (plen == 0) begin
      fill = 0;
      push_word(b, 1'b1);
      produced = 1;
    end else begin
      if (fill >= plen) fill = 0;
      window[fill] = b;
      fill++;
      if (fill == plen) begin
        hit = 1'b1;
        for (k = 0; k < plen; k++) begin
          if (window[k] != byte_at(match_lo, match_hi, k)) hit = 1'b0;
        end
        if (hit) begin
          for (k = 0; k < rlen; k++) push_word(byte_at(repl_lo, repl_hi, k), 1'b1);
          produced += rlen;
          fill = 0;
        end else begin
          push_word(window[0], 1'b1);
          produced++;
          for (k = 0; k < plen - 1; k++) window[k] = window[k+1];
          fill = plen - 1;
        end
      end
      if (fin) begin
        for (k = 0; k < fill; k++) push_word(window[k], 1'b1);
        produced += fill;
        fill = 0;
      end
    end
    if (fin) begin
      if (produced == 0) push_word(8'h00, 1'b0);
      last = due_q.pop_back();
      last.end_of_stream = 1'b1;
      due_q.push_back(last);
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : track
    sfr_pkg::out_word_t want;
    if (rst) begin
      match_lo  = '0;
      match_hi  = '0;
      match_len = '0;
      repl_lo   = '0;
      repl_hi   = '0;
      repl_len  = '0;
      fill      = 0;
      seen      = 0;
      errs      = 0;
      due_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sfr_pkg::CFG_MATCH_LO:  match_lo = cfg_data;
          sfr_pkg::CFG_MATCH_HI:  match_hi = cfg_data;
          sfr_pkg::CFG_MATCH_LEN: begin
            match_len = cfg_data[4:0];
            fill      = 0;
          end
          sfr_pkg::CFG_REPL_LO:   repl_lo = cfg_data;
          sfr_pkg::CFG_REPL_HI:   repl_hi = cfg_data;
          sfr_pkg::CFG_REPL_LEN:  repl_len = cfg_data[4:0];
          default: ;
        endcase
      end
      if (text_valid && text_ready) edit_text(text_data.data_byte, text_data.final_byte);
      if (edited_valid && edited_ready) begin
        seen++;
        if (due_q.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected, actual byte %02h valid %0b end %0b",
                   $time, edited_data.out_byte, edited_data.byte_valid,
                   edited_data.end_of_stream);
        end else begin
          want = due_q.pop_front();
          check_field("out_byte", want.out_byte, edited_data.out_byte);
          check_field("byte_valid", {7'b0, want.byte_valid}, {7'b0, edited_data.byte_valid});
          check_field("end_of_stream", {7'b0, want.end_of_stream},
                      {7'b0, edited_data.end_of_stream});
        end
      end
    end
    words_due  <= due_q.size();
    words_seen <= seen;
    mismatches <= errs;
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Stream find and replace testbench
// Drives text streams into the block under a series of register settings,
// first a few hand-picked cases, then random streams built mostly from copies
// of the pattern, with random idling on both channels. A separate checker
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 4000;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfr_pkg::REG_W-1:0]     cfg_data = '0;
  logic                          send_valid = 1'b0;
  sfr_pkg::in_word_t             send_word = '0;
  logic                          take_en = 1'b0;

  int words_due, words_seen, mismatches;
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int words_sent = 0;
  int streams_sent = 0;
  int settings_used = 0;
  int stall_cycles = 0;

  // Stimulus copy of the current pattern, used to build matching text.
  logic [7:0] pattern [16];
  logic [7:0] alphabet [3];
  logic [4:0] cur_mlen;
  int         pattern_len = 0;
  int         pat_pos = -1;

  sfr_stream_if #(.T(sfr_pkg::in_word_t))  text_ch ();
  sfr_stream_if #(.T(sfr_pkg::out_word_t)) edited_ch ();

  assign text_ch.valid   = send_valid;
  assign text_ch.data    = send_word;
  assign edited_ch.ready = take_en;

  stream_find_replace u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text_ch),
    .edited    (edited_ch)
  );

  sfr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .text_valid   (text_ch.valid),
    .text_ready   (text_ch.ready),
    .text_data    (text_ch.data),
    .edited_valid (edited_ch.valid),
    .edited_ready (edited_ch.ready),
    .edited_data  (edited_ch.data),
    .words_due    (words_due),
    .words_seen   (words_seen),
    .mismatches   (mismatches)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      take_en <= 1'b0;
    end else begin
      take_en <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((text_ch.valid && text_ch.ready) || (edited_ch.valid && edited_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves cfg_write high; the caller lowers it after its last write.
  task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfr_pkg::REG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_setting(input logic [63:0] mlo, input logic [63:0] mhi,
                              input logic [4:0] mlen, input logic [63:0] rlo,
                              input logic [63:0] rhi, input logic [4:0] rlen);
    write_reg(sfr_pkg::CFG_MATCH_LO, mlo);
    write_reg(sfr_pkg::CFG_MATCH_HI, mhi);
    write_reg(sfr_pkg::CFG_MATCH_LEN, {59'b0, mlen});
    write_reg(sfr_pkg::CFG_REPL_LO, rlo);
    write_reg(sfr_pkg::CFG_REPL_HI, rhi);
    write_reg(sfr_pkg::CFG_REPL_LEN, {59'b0, rlen});
    cfg_write <= 1'b0;
    cur_mlen = mlen;
    settings_used++;
  endtask

  task automatic send_text(input logic [7:0] b, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      send_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    send_valid <= 1'b1;
    send_word  <= '{data_byte: b, final_byte: fin};
    do @(posedge clk); while (!text_ch.ready);
    words_sent++;
    if (fin) streams_sent++;
  endtask

  // Waits until every predicted word has left, then lets the pipeline settle
  // since a byte that only fills the window leaves nothing to wait for.
  task automatic wait_drained();
    send_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_string(input string s, input logic fin_at_end);
    int i;
    for (i = 0; i < s.len(); i++) begin
      send_text(s[i], fin_at_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] next_text_byte();
    int         roll;
    logic [7:0] b;
    if (pat_pos < 0) begin
      roll = int'($urandom_range(99));
      if (pattern_len > 0 && roll < 55) begin
        pat_pos = 0;
      end else if (roll < 85) begin
        return alphabet[$urandom_range(2)];
      end else begin
        return 8'($urandom);
      end
    end
    b = pattern[pat_pos];
    pat_pos++;
    // Now and then a copy breaks off early.
    if (pat_pos >= pattern_len || $urandom_range(99) < 4) pat_pos = -1;
    return b;
  endfunction

  task automatic random_setting(input int pick);
    logic [127:0] mpat;
    logic [127:0] rpat;
    logic [4:0]   mlen;
    logic [4:0]   rlen;
    int           k;
    for (k = 0; k < 3; k++) alphabet[k] = 8'($urandom);
    for (k = 0; k < 16; k++) begin
      pattern[k]     = alphabet[$urandom_range(2)];
      mpat[8*k +: 8] = pattern[k];
    end
    rpat = {$urandom, $urandom, $urandom, $urandom};
    case (pick % 6)
      0:       mlen = 5'd0;
      1:       mlen = 5'd1;
      2:       mlen = 5'd16;
      3:       mlen = 5'd31;
      4:       mlen = 5'(17 + $urandom_range(13));
      default: mlen = 5'($urandom_range(6, 2));
    endcase
    case (pick % 5)
      0:       rlen = 5'd0;
      1:       rlen = 5'd16;
      2:       rlen = 5'($urandom_range(31, 17));
      default: rlen = 5'($urandom_range(8, 1));
    endcase
    pattern_len = (mlen > 5'd16) ? 16 : int'(mlen);
    pat_pos = -1;
    load_setting(mpat[63:0], mpat[127:64], mlen, rpat[63:0], rpat[127:64], rlen);
  endtask

  task automatic send_block(input int count);
    int         i;
    logic       fin;
    logic [7:0] b;
    for (i = 0; i < count; i++) begin
      b   = next_text_byte();
      fin = (i == count - 1) || ($urandom_range(99) < 8);
      send_text(b, fin);
      if (fin) begin
        pat_pos = -1;
      end else if ($urandom_range(99) < 3) begin
        // Rewriting the pattern length mid-stream throws the window away.
        wait_drained();
        write_reg(sfr_pkg::CFG_MATCH_LEN, {59'b0, cur_mlen});
        cfg_write <= 1'b0;
      end
    end
  endtask

  initial begin
    int phase;
    int s;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 8;
    take_idle_pct = 62;

    // Reset registers give straight pass-through.
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b1);

    // Pattern "abc" becomes "XY"; the stream ends on a partial match.
    wait_drained();
    load_setting(64'h636261, 64'h0, 5'd3, 64'h5958, 64'h0, 5'd2);
    send_string("abcab", 1'b1);

    // Matches deleted; pattern length and bytes rewritten with "ab" held in
    // the window, so those bytes are lost and the final "abd" match leaves
    // only a bare end marker.
    wait_drained();
    write_reg(sfr_pkg::CFG_REPL_LEN, 64'd0);
    cfg_write <= 1'b0;
    send_string("ab", 1'b0);
    wait_drained();
    write_reg(sfr_pkg::CFG_MATCH_LEN, 64'd3);
    write_reg(sfr_pkg::CFG_MATCH_LO, 64'h646261);
    cfg_write <= 1'b0;
    send_string("abd", 1'b1);

    // Oversized lengths saturate to a full 16-byte pattern and replacement.
    wait_drained();
    load_setting(64'hFF00_FF00_FF00_FF00, 64'h00FF_00FF_00FF_00FF, 5'd31,
                 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd31);
    for (s = 0; s < 16; s++) begin
      send_text((s[0] ^ s[3]) ? 8'hFF : 8'h00, s == 15);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          take_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          take_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      for (s = 0; s < 4; s++) begin
        wait_drained();
        random_setting(phase * 4 + s);
        send_block(34);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d text words in %0d streams under %0d register settings,",
             words_sent, streams_sent, settings_used);
    $display("and compared %0d result words with the predicted edit.", words_seen);
    if (mismatches == 0 && words_due == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
